// ----- hw/rtl/upd_pkg.sv -----
// Package for the URL percent decoder: character codes, result word type, hex helper.
package upd_pkg;

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned MAX_RESULTS = 3;

	localparam logic REG_MAX_OUT_LEN = 1'b0;
	localparam logic [7:0] MAX_OUT_LEN_RESET = 8'd95;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} res_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] nibble;
	} hex_t;

	// Decodes one hex digit in either case; valid is low for anything else.
	function automatic hex_t hex_decode(input logic [7:0] ch);
		hex_t r;
		r.valid  = 1'b0;
		r.nibble = 4'd0;
		if (ch >= CH_ZERO && ch <= CH_ZERO + 8'd9) begin
			r.valid  = 1'b1;
			r.nibble = 4'(ch - CH_ZERO);
		end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_A + 8'd5) begin
			r.valid  = 1'b1;
			r.nibble = 4'(ch - CH_UPPER_A + 8'd10);
		end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_A + 8'd5) begin
			r.valid  = 1'b1;
			r.nibble = 4'(ch - CH_LOWER_A + 8'd10);
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/url_percent_decoder.sv -----
// URL percent decoder top level: input register, decode logic, result queue, APB register.
//
// The input channel (in_valid/in_ready, in_char, is_end) takes one encoded word per ready cycle.
// The output channel (out_valid/out_ready, out_char, out_end) returns decoded words in order.
// A '+' becomes a space, '%' and two hex digits become one byte, and a broken percent
// sequence is passed through literally. A word with is_end set flushes any held '%' and
// digit and then returns an end marker (out_char zero, out_end high).
// At most max_out_len characters are returned per string; later ones are dropped.
// max_out_len lies at APB byte address 0 and resets to 95; pready is always high.
// A word's results pass from the input register into the result queue, which drives the output.
// Throughput is one word per cycle while each word yields at most one result and the
// receiver keeps up; a word that yields two or three results holds the input register
// until the four-entry result queue has drained to one entry.
// A stalled receiver leaves two or more results in the queue and then deasserts in_ready.
// Reset clears the input register, the queue, the held sequence and the character count.
module url_percent_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       is_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       out_end,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;
	logic       adv_s1;

	logic [7:0] max_len_q;
	logic [1:0] held_count_q;
	logic [7:0] held_digit_q;
	logic [7:0] emitted_q;

	upd_pkg::res_t fifo_q [upd_pkg::FIFO_DEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	// Decode results.
	logic [7:0] put_ch [upd_pkg::MAX_RESULTS];
	logic [1:0] n_put;
	logic [1:0] n_emit;
	logic [1:0] n_push;
	logic [7:0] avail;
	logic [1:0] held_count_d;
	logic [7:0] held_digit_d;
	upd_pkg::res_t res [upd_pkg::MAX_RESULTS];
	upd_pkg::hex_t hex_in;
	upd_pkg::hex_t hex_held;
	logic pop;

	// APB register port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == upd_pkg::REG_MAX_OUT_LEN) ? {24'd0, max_len_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= upd_pkg::MAX_OUT_LEN_RESET;
		end else if (psel && penable && pwrite && paddr[2] == upd_pkg::REG_MAX_OUT_LEN) begin
			max_len_q <= pwdata[7:0];
		end
	end

	// The input register moves on only when the queue can take three results.
	assign adv_s1   = valid_s1 && (count_q <= 3'd1);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= in_char;
			end_s1  <= is_end;
		end
	end

	// Build the list of characters to put, before the length limit is applied.
	always_comb begin
		hex_in       = upd_pkg::hex_decode(char_s1);
		hex_held     = upd_pkg::hex_decode(held_digit_q);
		held_count_d = 2'd0;
		held_digit_d = held_digit_q;
		n_put        = 2'd0;
		for (int i = 0; i < upd_pkg::MAX_RESULTS; i++) begin
			put_ch[i] = 8'd0;
		end
		if (end_s1) begin
			if (held_count_q == 2'd1 || held_count_q == 2'd2) begin
				put_ch[0] = upd_pkg::CH_PERCENT;
				n_put     = 2'd1;
			end
			if (held_count_q == 2'd2) begin
				put_ch[1] = held_digit_q;
				n_put     = 2'd2;
			end
		end else if (held_count_q == 2'd1 && hex_in.valid) begin
			held_digit_d = char_s1;
			held_count_d = 2'd2;
		end else if (held_count_q == 2'd2 && hex_in.valid) begin
			put_ch[0] = {hex_held.nibble, hex_in.nibble};
			n_put     = 2'd1;
		end else begin
			// A broken sequence is flushed literally before the new character.
			if (held_count_q == 2'd1 || held_count_q == 2'd2) begin
				put_ch[0] = upd_pkg::CH_PERCENT;
				n_put     = 2'd1;
			end
			if (held_count_q == 2'd2) begin
				put_ch[1] = held_digit_q;
				n_put     = 2'd2;
			end
			if (char_s1 == upd_pkg::CH_PERCENT) begin
				held_count_d = 2'd1;
			end else begin
				put_ch[n_put] = (char_s1 == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : char_s1;
				n_put         = n_put + 2'd1;
			end
		end
	end

	// Apply the length limit and append the end marker.
	always_comb begin
		avail  = (max_len_q > emitted_q) ? (max_len_q - emitted_q) : 8'd0;
		n_emit = (avail < {6'd0, n_put}) ? avail[1:0] : n_put;
		n_push = n_emit + {1'b0, end_s1};
		for (int i = 0; i < upd_pkg::MAX_RESULTS; i++) begin
			res[i].ch  = put_ch[i];
			res[i].fin = 1'b0;
			if (2'(i) == n_emit) begin
				res[i].ch  = 8'd0;
				res[i].fin = end_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= 2'd0;
			emitted_q    <= 8'd0;
		end else if (adv_s1) begin
			held_count_q <= held_count_d;
			emitted_q    <= end_s1 ? 8'd0 : emitted_q + {6'd0, n_emit};
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			held_digit_q <= held_digit_d;
		end
	end

	// Result queue.
	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != 3'd0);
	assign out_char  = fifo_q[rd_ptr_q].ch;
	assign out_end   = fifo_q[rd_ptr_q].fin;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int i = 0; i < upd_pkg::MAX_RESULTS; i++) begin
				if (2'(i) < n_push) begin
					fifo_q[wr_ptr_q + 2'(i)] <= res[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (adv_s1) begin
				wr_ptr_q <= wr_ptr_q + n_push;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (adv_s1 ? {1'b0, n_push} : 3'd0) - {2'd0, pop};
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue overflow");

	a_room_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |-> (count_q <= 3'd1 && n_push <= 2'd3))
		else $error("input register advanced without queue room");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && end_s1) |=> (emitted_q == 8'd0 && held_count_q == 2'd0))
		else $error("terminator did not clear string state");

	a_held_legal: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q != 2'd3)
		else $error("held count reached three");

	a_emit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !end_s1 && emitted_q <= max_len_q) |=>
		(emitted_q <= $past(max_len_q)))
		else $error("emitted count passed the length limit");

endmodule

// ----- tb/upd_checker.sv -----
`timescale 1ns / 100ps
// Checker for the URL percent decoder: predicts decoded words and compares them on the output.
module upd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_char,
	input  logic        is_end,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_char,
	input  logic        out_end,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          words_owed
);

	upd_pkg::res_t owed_q[$];
	logic [7:0] max_len;
	logic [1:0] held_cnt;
	logic [7:0] held_digit;
	logic [7:0] char_cnt;
	int         mismatch_cnt = 0;
	int         owed_cnt = 0;

	assign mismatches = mismatch_cnt;
	assign words_owed = owed_cnt;

	// Nibble value of a hex digit, or 16 for anything else.
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= upd_pkg::CH_ZERO && c <= upd_pkg::CH_ZERO + 8'd9)
			return 5'(c - upd_pkg::CH_ZERO);
		if (c >= upd_pkg::CH_UPPER_A && c <= upd_pkg::CH_UPPER_A + 8'd5)
			return 5'(c - upd_pkg::CH_UPPER_A) + 5'd10;
		if (c >= upd_pkg::CH_LOWER_A && c <= upd_pkg::CH_LOWER_A + 8'd5)
			return 5'(c - upd_pkg::CH_LOWER_A) + 5'd10;
		return 5'd16;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatch_cnt++;
	endtask

	// Characters past the length limit of the current string are dropped.
	task automatic put_char(input logic [7:0] c);
		upd_pkg::res_t r;
		if (char_cnt >= max_len)
			return;
		char_cnt = char_cnt + 8'd1;
		r.ch  = c;
		r.fin = 1'b0;
		owed_q.push_back(r);
	endtask

	task automatic start_fresh(input logic [7:0] c);
		if (c == upd_pkg::CH_PLUS) begin
			put_char(upd_pkg::CH_SPACE);
		end else if (c == upd_pkg::CH_PERCENT) begin
			held_cnt = 2'd1;
		end else begin
			put_char(c);
		end
	endtask

	task automatic decode_word(input logic [7:0] c, input logic fin);
		logic [4:0]    lo;
		logic [4:0]    hi;
		upd_pkg::res_t r;
		if (fin) begin
			if (held_cnt == 2'd1 || held_cnt == 2'd2)
				put_char(upd_pkg::CH_PERCENT);
			if (held_cnt == 2'd2)
				put_char(held_digit);
			r.ch  = 8'd0;
			r.fin = 1'b1;
			owed_q.push_back(r);
			held_cnt = 2'd0;
			char_cnt = 8'd0;
		end else begin
			case (held_cnt)
				2'd1: begin
					if (nibble_of(c) < 5'd16) begin
						held_digit = c;
						held_cnt   = 2'd2;
					end else begin
						held_cnt = 2'd0;
						put_char(upd_pkg::CH_PERCENT);
						start_fresh(c);
					end
				end
				2'd2: begin
					lo       = nibble_of(c);
					held_cnt = 2'd0;
					if (lo < 5'd16) begin
						hi = nibble_of(held_digit);
						put_char({hi[3:0], lo[3:0]});
					end else begin
						put_char(upd_pkg::CH_PERCENT);
						put_char(held_digit);
						start_fresh(c);
					end
				end
				default: begin
					held_cnt = 2'd0;
					start_fresh(c);
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		upd_pkg::res_t want;
		if (!arst_n) begin
			owed_q.delete();
			max_len    = upd_pkg::MAX_OUT_LEN_RESET;
			held_cnt   = 2'd0;
			held_digit = 8'd0;
			char_cnt   = 8'd0;
		end else begin
			if (psel && penable && pwrite && pready &&
				paddr == {upd_pkg::REG_MAX_OUT_LEN, 2'b00})
				max_len = pwdata[7:0];
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word, char %h end %b",
						out_char, out_end));
				end else begin
					want = owed_q.pop_front();
					if (out_char !== want.ch)
						report_mismatch($sformatf("out_char %h, expected %h",
							out_char, want.ch));
					if (out_end !== want.fin)
						report_mismatch($sformatf("out_end %b, expected %b",
							out_end, want.fin));
				end
			end
			if (in_valid && in_ready)
				decode_word(in_char, is_end);
		end
		owed_cnt = owed_q.size();
	end

endmodule

// ----- tb/tb_url_percent_decoder.sv -----
`timescale 1ns / 100ps
// Testbench top for the URL percent decoder: clock, reset, stimulus, register writes, verdict.
module tb_url_percent_decoder;

	localparam int STALL_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_char = 8'd0;
	logic        is_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_char;
	logic        out_end;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int words_owed;
	int in_idle_pct = 20;
	int out_idle_pct = 88;
	int words_sent = 0;
	int stall_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	url_percent_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_char   (in_char),
		.is_end    (is_end),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.out_end   (out_end),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	upd_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_char    (in_char),
		.is_end     (is_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.out_end    (out_end),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (mismatches),
		.words_owed (words_owed)
	);

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	// Ends the run when neither channel nor the register port has moved for too long.
	initial begin
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_word(input logic [7:0] c, input logic fin);
		@(negedge clk);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_char  <= c;
		is_end   <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], 1'b0);
	endtask

	task automatic write_max_len(input logic [7:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {upd_pkg::REG_MAX_OUT_LEN, 2'b00};
		pwdata  <= {24'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// A word that yields nothing may still sit inside the block, so wait SETTLE_CYCLES more.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (words_owed != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] hex_char();
		int n;
		n = $urandom_range(21);
		if (n < 10)
			return upd_pkg::CH_ZERO + 8'(n);
		if (n < 16)
			return upd_pkg::CH_LOWER_A + 8'(n - 10);
		return upd_pkg::CH_UPPER_A + 8'(n - 16);
	endfunction

	function automatic logic [7:0] non_hex_char();
		case ($urandom_range(3))
			0:       return 8'($urandom_range(47));
			1:       return 8'($urandom_range(64, 58));
			2:       return 8'($urandom_range(96, 71));
			default: return 8'($urandom_range(255, 103));
		endcase
	endfunction

	// Mostly well-formed escapes and plain text, with broken escapes, raw bytes and string ends mixed in.
	task automatic send_token();
		int pick;
		pick = $urandom_range(99);
		if (pick < 35) begin
			send_word(upd_pkg::CH_PERCENT, 1'b0);
			send_word(hex_char(), 1'b0);
			send_word(hex_char(), 1'b0);
		end else if (pick < 45) begin
			send_word(upd_pkg::CH_PERCENT, 1'b0);
			if ($urandom_range(1) == 1)
				send_word(hex_char(), 1'b0);
			if ($urandom_range(3) == 0)
				send_word(8'($urandom), 1'b1);
			else
				send_word(non_hex_char(), 1'b0);
		end else if (pick < 55) begin
			send_word(upd_pkg::CH_PLUS, 1'b0);
		end else if (pick < 62) begin
			send_word(8'($urandom), 1'b1);
		end else if (pick < 80) begin
			send_word(8'($urandom_range(126, 32)), 1'b0);
		end else begin
			send_word(8'($urandom), 1'b0);
		end
	endtask

	task automatic run_words(input int n);
		int first;
		first = words_sent;
		while (words_sent - first < n)
			send_token();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words under the reset length limit.
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_text("+%aF%z%4g%%09%");
		send_word(8'hFF, 1'b1);
		send_text("%B");
		send_word(8'h00, 1'b1);
		// A short limit makes the output fill up in the middle of a broken escape.
		settle();
		write_max_len(8'd2);
		send_text("x%+y");
		send_word(8'h5A, 1'b1);

		settle();
		write_max_len(8'd255);
		run_words(80);
		settle();
		write_max_len(8'd0);
		run_words(40);

		in_idle_pct  = 88;
		out_idle_pct = 20;
		settle();
		write_max_len(8'($urandom_range(254, 1)));
		run_words(80);
		settle();
		write_max_len(8'd4);
		run_words(70);

		in_idle_pct  = 0;
		out_idle_pct = 0;
		settle();
		write_max_len(upd_pkg::MAX_OUT_LEN_RESET);
		run_words(150);

		settle();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/upd_pkg.sv
hw/rtl/url_percent_decoder.sv
tb/upd_checker.sv
tb/tb_url_percent_decoder.sv
